/* rtl/hgpg_pkg.sv */
// ----------------------------------------------------------------------------
// hgpg_pkg: shared types and constants of the hexapod gait pattern generator
// Holds the register indexes, mode codes, servo order tables and the quarter
// sine table.
// ----------------------------------------------------------------------------
package hgpg_pkg;

  localparam int unsigned PhaseBits    = 10;
  localparam int unsigned SineFracBits = 14;
  localparam int unsigned BounceMax    = 11;
  localparam int unsigned QuarterSteps = 1 << (PhaseBits - 2);

  typedef enum logic [2:0] {
    RegMotionMode  = 3'd0,
    RegLiftHeight  = 3'd1,
    RegSwingLength = 3'd2,
    RegLegCenter   = 3'd3,
    RegFootCenter  = 3'd4,
    RegGaitPeriod  = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    ModeDebug   = 3'd0,
    ModeOrigin  = 3'd1,
    ModeIdle    = 3'd2,
    ModeStretch = 3'd3,
    ModeTapping = 3'd4,
    ModeWalk    = 3'd5
  } mode_e;

  // Channel order used by origin, tapping and walk: legs first, then feet.
  function automatic logic [3:0] order_ch(input logic [3:0] k);
    logic [3:0] r;
    unique case (k)
      4'd0: r = 4'd10;  4'd1: r = 4'd0;  4'd2: r = 4'd8;  4'd3: r = 4'd2;
      4'd4: r = 4'd6;   4'd5: r = 4'd4;  4'd6: r = 4'd11; 4'd7: r = 4'd1;
      4'd8: r = 4'd9;   4'd9: r = 4'd3;  4'd10: r = 4'd7; default: r = 4'd5;
    endcase
    return r;
  endfunction

  // Foot angle in the up phase of tapping, per leg slot.
  function automatic logic tap_is45(input logic [2:0] k);
    return (k == 3'd0) || (k == 3'd3) || (k == 3'd4);
  endfunction

  // Legs FR, CL and BR run in antiphase to the other three legs.
  function automatic logic walk_grp2(input logic [2:0] k);
    return (k == 3'd1) || (k == 3'd2) || (k == 3'd5);
  endfunction

  // Shift-and-subtract quotient, used only while building the table.
  function automatic longint unsigned udiv64(input longint unsigned a,
                                             input longint unsigned d);
    longint unsigned q, rm;
    q = '0;
    rm = '0;
    for (int i = 63; i >= 0; i--) begin
      rm = {rm[62:0], a[i]};
      if (rm >= d) begin
        rm = rm - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Quarter sine, Q1.14, index 0..256, computed at elaboration.
  function automatic logic [SineFracBits:0] qsine(input int unsigned k);
    longint unsigned x, x2, s, t;
    x = (64'd1686629713 * k) >> (PhaseBits - 2);
    x2 = (x * x) >> 30;
    s = x;
    t = x;
    for (int n = 1; n <= 7; n++) begin
      t = udiv64((t * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
      if ((n & 1) == 1) s = s - t;
      else s = s + t;
    end
    s = (s + (64'd1 << (29 - SineFracBits))) >> (30 - SineFracBits);
    if (s > (64'd1 << SineFracBits)) s = 64'd1 << SineFracBits;
    return s[SineFracBits:0];
  endfunction

  typedef logic [SineFracBits:0] qsine_tab_t [QuarterSteps + 1];

  function automatic qsine_tab_t make_tab();
    qsine_tab_t tb;
    for (int unsigned i = 0; i <= QuarterSteps; i++) tb[i] = qsine(i);
    return tb;
  endfunction

  localparam qsine_tab_t QsineTab = make_tab();

endpackage

/* rtl/hexapod_gait_pattern_generator_core.sv */
// ----------------------------------------------------------------------------
// hexapod_gait_pattern_generator_core: twelve servo commands per motion tick
// ----------------------------------------------------------------------------
// Each accepted tick yields twelve command words in origin, stretching,
// tapping and walk modes, and none in debug or idle. A walk tick first runs
// a bit-serial divider for the phase, then the commands pass one per cycle
// through the shared multiply and clamp unit; other modes emit one command
// per cycle as well. Output stalls simply hold the sequencer. Input is
// accepted only while no tick is in progress and the last word has left.
module hexapod_gait_pattern_generator_core import hgpg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] tick_time_ms_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  servo_channel_o,
  output logic        servo_unit_o,
  output logic [2:0]  servo_port_o,
  output logic [7:0]  servo_angle_o,
  output logic        last_command_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StDiv  = 3'b010,
    StEmit = 3'b100
  } state_e;

  state_e      state_q, state_d;
  logic [2:0]  mode_q;
  logic [4:0]  lift_q;
  logic [5:0]  swing_q;
  logic [7:0]  legc_q, footc_q;
  logic [14:0] period_q;
  logic [3:0]  bcnt_q, bcnt_d;
  logic        bdown_q, bdown_d;
  logic        started_q;
  logic [31:0] origin_q;
  logic [3:0]  k_q;
  logic [PhaseBits-1:0] phase_q;
  logic        div_start, div_done;
  logic [PhaseBits-1:0] div_phase;
  logic [31:0] elapsed;
  logic        in_acc, emit_ok, produces, bmode_now;

  // Bounce state updates at accept; emitted values use the pre-update copy.
  logic [3:0] bcnt_use_q;
  logic       bdown_use_q;

  assign in_acc   = in_valid_i && in_ready_o;
  assign produces = (mode_q == ModeOrigin) || (mode_q == ModeStretch) ||
                    (mode_q == ModeTapping) || (mode_q == ModeWalk);
  assign in_ready_o  = (state_q == StIdle) && !out_valid_o;
  assign cfg_ready_o = 1'b1;
  assign elapsed = tick_time_ms_i - (started_q ? origin_q : tick_time_ms_i);
  assign div_start = in_acc && (mode_q == ModeWalk);
  assign bmode_now = (mode_q == ModeStretch) || (mode_q == ModeTapping);

  hgpg_divider u_div (
    .clk_i, .rst_ni,
    .start_i   (div_start),
    .elapsed_i (elapsed),
    .period_i  (period_q),
    .done_o    (div_done),
    .phase_o   (div_phase)
  );

  // Shared angle unit: one multiply, one add and a clamp per command.
  // Walk words alternate leg and foot of one slot.
  logic [2:0]  slot, wslot;
  logic        is_foot, wfoot;
  logic [PhaseBits-1:0] p, pa;
  logic [PhaseBits-3:0] r;
  logic [PhaseBits-2:0] tab_idx;
  logic [1:0]  quad;
  logic [SineFracBits:0] mag;
  logic signed [SineFracBits+1:0] sv;
  logic signed [6:0]  amp;
  logic signed [SineFracBits+24:0] prod, acc;
  logic [7:0]  walk_ang, ang, ch;
  logic [3:0]  chn;

  assign is_foot = (k_q >= 4'd6);
  assign slot    = is_foot ? 3'(k_q - 4'd6) : k_q[2:0];
  assign wslot   = k_q[3:1];
  assign wfoot   = k_q[0];
  assign p       = phase_q + (walk_grp2(wslot) ? PhaseBits'(1 << (PhaseBits - 1)) : '0);
  assign pa      = p + (wfoot ? '0 : PhaseBits'(1 << (PhaseBits - 2)));
  assign quad    = pa[PhaseBits-1:PhaseBits-2];
  assign r       = pa[PhaseBits-3:0];
  assign tab_idx = quad[0] ? (PhaseBits-1)'(QuarterSteps) - {1'b0, r} : {1'b0, r};

  always_comb begin
    mag = QsineTab[tab_idx];
    sv = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    if (wfoot && sv < 0) sv = '0;
    amp  = wfoot ? -$signed({2'b0, lift_q}) : $signed({1'b0, swing_q});
    prod = sv * amp;
    acc  = $signed({17'd0, wfoot ? footc_q : legc_q, SineFracBits'(0)}) + prod;
    if (acc < $signed((SineFracBits+25)'(45) <<< SineFracBits)) walk_ang = 8'd45;
    else if (acc[SineFracBits+24:SineFracBits] > 135) walk_ang = 8'd135;
    else walk_ang = acc[SineFracBits+7:SineFracBits];
  end

  always_comb begin
    chn = order_ch(k_q);
    ang = 8'd90;
    unique case (mode_q)
      ModeStretch: begin
        chn = k_q;
        ang = 8'(90 - BounceMax) + {3'b0, bcnt_use_q, 1'b0};
      end
      ModeTapping: begin
        if (is_foot) ang = (tap_is45(slot) ^ bdown_use_q) ? 8'd45 : 8'd90;
      end
      ModeWalk: begin
        chn = order_ch({1'b0, wslot}) + {3'b0, wfoot};
        ang = walk_ang;
      end
      default: ang = 8'd90;
    endcase
  end
  assign ch = {4'b0, chn};

  // Output register.
  logic        ov_q;
  logic [3:0]  och_q;
  logic [7:0]  oang_q;
  logic        olast_q;

  assign emit_ok = (state_q == StEmit) && (!ov_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    bcnt_d  = bcnt_q;
    bdown_d = bdown_q;
    unique case (state_q)
      StIdle: if (in_acc && produces) state_d = (mode_q == ModeWalk) ? StDiv : StEmit;
      StDiv:  if (div_done) state_d = StEmit;
      StEmit: if (emit_ok && k_q == 4'd11) state_d = StIdle;
      default: state_d = StIdle;
    endcase
    if (in_acc && bmode_now) begin
      bdown_d = (bcnt_q == '0) ? 1'b0 : (bcnt_q >= 4'(BounceMax)) ? 1'b1 : bdown_q;
      bcnt_d  = bdown_d ? bcnt_q - 4'd1 : bcnt_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      mode_q    <= ModeOrigin;
      lift_q    <= 5'd15;
      swing_q   <= 6'd25;
      legc_q    <= 8'd90;
      footc_q   <= 8'd60;
      period_q  <= 15'd2500;
      bcnt_q    <= '0;
      bdown_q   <= 1'b0;
      started_q <= 1'b0;
      origin_q  <= '0;
      k_q       <= '0;
      ov_q      <= 1'b0;
      bcnt_use_q  <= '0;
      bdown_use_q <= 1'b0;
    end else begin
      state_q <= state_d;
      bcnt_q  <= bcnt_d;
      bdown_q <= bdown_d;
      if (in_acc) begin
        bcnt_use_q  <= bcnt_q;
        bdown_use_q <= bdown_q;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegMotionMode:  mode_q   <= cfg_data_i[2:0];
          RegLiftHeight:  lift_q   <= cfg_data_i[4:0];
          RegSwingLength: swing_q  <= cfg_data_i[5:0];
          RegLegCenter:   legc_q   <= cfg_data_i[7:0];
          RegFootCenter:  footc_q  <= cfg_data_i[7:0];
          RegGaitPeriod: begin
            period_q  <= cfg_data_i;
            started_q <= 1'b0;
            origin_q  <= '0;
          end
          default: ;
        endcase
      end
      if (div_start && !started_q) begin
        started_q <= 1'b1;
        origin_q  <= tick_time_ms_i;
      end
      if (in_acc) k_q <= '0;
      else if (emit_ok) k_q <= k_q + 4'd1;
      if (emit_ok) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_done) phase_q <= div_phase;
    if (emit_ok) begin
      och_q   <= ch[3:0];
      oang_q  <= ang;
      olast_q <= (k_q == 4'd11);
    end
  end

  assign out_valid_o     = ov_q;
  assign servo_channel_o = och_q;
  assign servo_unit_o    = och_q[3];
  assign servo_port_o    = och_q[2:0];
  assign servo_angle_o   = oang_q;
  assign last_command_o  = olast_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !out_valid_o) else $error("tick accepted with result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(servo_angle_o))
    else $error("stalled command changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == StDiv) else $error("divider finished outside walk");

endmodule

/* rtl/hgpg_divider.sv */
// ----------------------------------------------------------------------------
// hgpg_divider: restoring divider for the walk phase
// Computes (e mod P) then floor(rem * 1024 / P), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hgpg_divider import hgpg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [31:0]          elapsed_i,
  input  logic [14:0]          period_i,
  output logic                 done_o,
  output logic [PhaseBits-1:0] phase_o
);

  localparam int unsigned Steps = 32 + PhaseBits;

  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [15:0] rem_q, rem_d;
  logic [31:0] num_q, num_d;
  logic [PhaseBits-1:0] quo_q, quo_d;
  logic [16:0] trial;
  logic        phase2;

  assign phase2 = (cnt_q >= 6'd32);
  assign trial  = {rem_q, phase2 ? 1'b0 : num_q[31]} - {2'b0, period_i};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      num_d  = elapsed_i;
      quo_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[30:0], 1'b0};
      if (!trial[16]) rem_d = trial[15:0];
      else rem_d = {rem_q[14:0], phase2 ? 1'b0 : num_q[31]};
      if (phase2) quo_d = {quo_q[PhaseBits-2:0], ~trial[16]};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(Steps - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    quo_q <= quo_d;
  end

  assign done_o  = busy_q && (cnt_q == 6'(Steps - 1));
  assign phase_o = (period_i == '0) ? '0 : {quo_q[PhaseBits-2:0], ~trial[16]};

endmodule
